// ===== rtl/fud_pkg.sv =====
// shared types, character codes and hex helpers for the form-encoded decoder
// no dependencies; used by fud_front, fud_queue, fud_back and the top level
package fud_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    localparam int unsigned MAX_OUT = 3;

    // one classified input word: up to three output bytes, last mark on the final one
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] data;
        logic [1:0]              count;
        logic                    last;
    } t_cmd;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
               ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c <= CH_9) begin
            v = c - CH_0;
        end else if (c <= CH_UF) begin
            v = c - CH_UA + HEX_TEN;
        end else begin
            v = c - CH_LA + HEX_TEN;
        end
        return v[3:0];
    endfunction

endpackage

// ===== rtl/fud_front.sv =====
// front part: tracks held percent and digit, turns input words into commands
// depends on fud_pkg
module fud_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_push,
    output fud_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_PCT   = 2'd1,
        HELD_DIGIT = 2'd2
    } t_held;

    t_held      r_held, n_held;
    logic [7:0] r_digit, n_digit;

    logic [fud_pkg::MAX_OUT-1:0][7:0] bytes;
    logic [1:0] cnt;
    logic       plain;
    logic       b_hex;

    always_comb begin
        bytes   = '0;
        cnt     = 2'd0;
        plain   = 1'b1;
        n_held  = r_held;
        n_digit = r_digit;
        b_hex   = fud_pkg::is_hex(i_byte);
        unique case (r_held)
            HELD_DIGIT: begin
                n_held = HELD_NONE;
                if (b_hex) begin
                    bytes[0] = {fud_pkg::hex_value(r_digit), fud_pkg::hex_value(i_byte)};
                    cnt      = 2'd1;
                    plain    = 1'b0;
                end else begin
                    bytes[0] = fud_pkg::CH_PCT;
                    bytes[1] = r_digit;
                    cnt      = 2'd2;
                end
            end
            HELD_PCT: begin
                if (b_hex) begin
                    plain = 1'b0;
                    if (i_last) begin
                        bytes[0] = fud_pkg::CH_PCT;
                        bytes[1] = i_byte;
                        cnt      = 2'd2;
                        n_held   = HELD_NONE;
                    end else begin
                        n_digit = i_byte;
                        n_held  = HELD_DIGIT;
                    end
                end else begin
                    bytes[0] = fud_pkg::CH_PCT;
                    cnt      = 2'd1;
                    n_held   = HELD_NONE;
                end
            end
            default: begin
                n_held = HELD_NONE;
            end
        endcase
        // fresh handling of the byte after any flushed prefix
        if (plain) begin
            if (i_byte == fud_pkg::CH_PCT) begin
                if (i_last) begin
                    bytes[cnt] = fud_pkg::CH_PCT;
                    cnt        = cnt + 2'd1;
                end else begin
                    n_held = HELD_PCT;
                end
            end else begin
                bytes[cnt] = (i_byte == fud_pkg::CH_PLUS) ? fud_pkg::CH_SPACE : i_byte;
                cnt        = cnt + 2'd1;
            end
        end
    end

    assign o_cmd.data  = bytes;
    assign o_cmd.count = cnt;
    assign o_cmd.last  = i_last;
    assign o_push      = i_accept && (cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= HELD_NONE;
            r_digit <= '0;
        end else if (i_accept) begin
            r_held  <= n_held;
            r_digit <= n_digit;
        end
    end

    // a string end never leaves anything held
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> r_held == HELD_NONE)
        else $error("held state survives end of string");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |-> o_push)
        else $error("end of string without a result");

endmodule

// ===== rtl/fud_queue.sv =====
// short command queue between the front and back parts
// depends on fud_pkg
module fud_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fud_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output fud_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    fud_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

// ===== rtl/fud_back.sv =====
// back part: steps through each command's bytes into the output register
// depends on fud_pkg
module fud_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fud_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [7:0]    o_out_byte,
    output logic          o_out_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       final_byte;

    assign load       = !i_empty && (!r_valid || !i_out_stall);
    assign final_byte = (r_idx == i_head.count - 2'd1);
    assign o_pop      = load && final_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= final_byte ? 2'd0 : r_idx + 2'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.data[r_idx];
            r_last <= i_head.last && final_byte;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_out_last  = r_last;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> r_idx < i_head.count)
        else $error("byte index past command length");

endmodule

// ===== rtl/form_urlencoded_decoder.sv =====
// top level of the streaming form-encoded text decoder
// depends on fud_pkg, fud_front, fud_queue, fud_back
//
//  channel   direction  handshake                      payload
//  input     in         i_in_valid / o_in_stall        i_in_byte, i_in_last
//  output    out        o_out_valid / i_out_stall      o_out_byte, o_out_last
//
// one input word per cycle while the command queue has room
// each word yields zero to three output words, sent one per cycle unless stalled
// an accepted word goes into the queue, then from its head into the output register
// reset is synchronous, active low; it empties the queue and drops any held escape
// o_in_stall comes only from the queue being full; output stalls only hold the register
module form_urlencoded_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    fud_pkg::t_cmd cmd;
    fud_pkg::t_cmd head;

    // input taken whenever the queue can absorb a command
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    // classify against the held escape state
    fud_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    // decouples classification from byte emission
    fud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // one output word per cycle out of the head command, unless the output stalls
    fud_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule
